// ----- rtl/core/fca_pkg.sv -----
`default_nettype none

package fca_pkg;

  // Fixed limits and field widths of the block.
  localparam int unsigned MAX_POLS     = 4;
  localparam int unsigned MAX_GROUP    = 256;
  localparam int unsigned MAX_CHANNELS = 4096;
  localparam int unsigned SAMPLE_BITS  = 16;

  localparam int unsigned POL_W  = 2;
  localparam int unsigned NP_W   = 3;
  localparam int unsigned GRP_W  = 9;
  localparam int unsigned SCH_W  = 12;
  localparam int unsigned NCH_W  = 13;
  localparam int unsigned AMP_W  = 16;
  localparam int unsigned OCH_W  = 12;
  localparam int unsigned CHAN_W = 14;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_POLS      = 3'd0,
    CFG_GROUP_SIZE    = 3'd1,
    CFG_START_CHANNEL = 3'd2,
    CFG_NUM_CHANNELS  = 3'd3,
    CFG_AMP_LIMIT     = 3'd4
  } cfg_idx_e;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_GRD,
    ST_GLD,
    ST_GDIV,
    ST_GSQ,
    ST_GCMP,
    ST_EMIT
  } state_e;

  // One entry of the per-polarization accumulator memory.
  typedef struct packed {
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic [CNT_W-1:0]        cnt;
  } acc_t;

endpackage

`default_nettype wire

// ----- rtl/core/fca_in_if.sv -----
`default_nettype none

interface fca_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fca_pkg::SAMPLE_BITS-1:0] data_re;
  logic signed [fca_pkg::SAMPLE_BITS-1:0] data_im;
  logic                                 flagged;
  logic                                 first_of_row;

  modport source (output valid, data_re, data_im, flagged, first_of_row, input ready);
  modport sink (input valid, data_re, data_im, flagged, first_of_row, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fca_out_if.sv -----
`default_nettype none

interface fca_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fca_pkg::SAMPLE_BITS-1:0] avg_re;
  logic signed [fca_pkg::SAMPLE_BITS-1:0] avg_im;
  logic [fca_pkg::POL_W-1:0]              pol_index;
  logic [fca_pkg::OCH_W-1:0]              out_channel;
  logic                                   group_flag;
  logic                                   last;

  modport source (output valid, avg_re, avg_im, pol_index, out_channel, group_flag, last,
                  input ready);
  modport sink (input valid, avg_re, avg_im, pol_index, out_channel, group_flag, last,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fca_div.sv -----
`default_nettype none

// Restoring divider for a complex sum by an unsigned count, one quotient bit
// per cycle on both lanes; the quotient is truncated toward zero.
module fca_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [fca_pkg::SUM_W-1:0]       num_re_i,
  input  logic signed [fca_pkg::SUM_W-1:0]       num_im_i,
  input  logic [fca_pkg::CNT_W-1:0]              den_i,
  output logic                                   done_o,
  output logic signed [fca_pkg::SAMPLE_BITS-1:0] quo_re_o,
  output logic signed [fca_pkg::SAMPLE_BITS-1:0] quo_im_o
);

  localparam int unsigned SW = fca_pkg::SUM_W;
  localparam int unsigned CW = fca_pkg::CNT_W;
  localparam int unsigned IW = $clog2(SW);

  logic          busy_q, done_q;
  logic [IW-1:0] iter_q;
  logic [CW-1:0] den_q;
  logic          neg_re_q, neg_im_q;
  logic [SW-1:0] q_re_q, q_im_q;
  logic [CW-1:0] r_re_q, r_im_q;
  logic [SW-1:0] q_re_d, q_im_d;
  logic [CW-1:0] r_re_d, r_im_d;
  logic [SW-1:0] res_re, res_im;

  // One restoring step: shift in the next dividend bit and try a subtract.
  function automatic logic [CW+SW-1:0] div_step(input logic [CW-1:0] rem,
                                                input logic [SW-1:0] q,
                                                input logic [CW-1:0] den);
    logic [CW:0]   t;
    logic          ge;
    logic [CW:0]   r;
    t  = {rem, q[SW-1]};
    ge = (t >= {1'b0, den});
    r  = ge ? (t - {1'b0, den}) : t;
    return {r[CW-1:0], q[SW-2:0], ge};
  endfunction

  always_comb begin
    {r_re_d, q_re_d} = div_step(r_re_q, q_re_q, den_q);
    {r_im_d, q_im_d} = div_step(r_im_q, q_im_q, den_q);
  end

  // Control of the iteration count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        if (iter_q == IW'(SW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          iter_q <= iter_q + IW'(1);
        end
      end
    end
  end

  // Datapath: magnitudes go in, quotient bits shift in behind them.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q    <= den_i;
      neg_re_q <= num_re_i[SW-1];
      neg_im_q <= num_im_i[SW-1];
      q_re_q   <= num_re_i[SW-1] ? SW'(-num_re_i) : SW'(num_re_i);
      q_im_q   <= num_im_i[SW-1] ? SW'(-num_im_i) : SW'(num_im_i);
      r_re_q   <= '0;
      r_im_q   <= '0;
    end else if (busy_q) begin
      q_re_q <= q_re_d;
      q_im_q <= q_im_d;
      r_re_q <= r_re_d;
      r_im_q <= r_im_d;
    end
  end

  assign res_re   = neg_re_q ? (~q_re_q + SW'(1)) : q_re_q;
  assign res_im   = neg_im_q ? (~q_im_q + SW'(1)) : q_im_q;
  assign quo_re_o = res_re[fca_pkg::SAMPLE_BITS-1:0];
  assign quo_im_o = res_im[fca_pkg::SAMPLE_BITS-1:0];
  assign done_o   = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/flagged_channel_averager_top.sv -----
// Flag-aware channel averager.
// Samples arrive on in_i, channel by channel with the polarizations of a
// channel in order; first_of_row marks the first sample of a row and drops
// any partial group. Unflagged samples of the used channel window are summed
// per polarization in a four-entry accumulator memory.
// An input transfer reads the accumulator entry in ST_IDLE, then adds and
// writes it back in ST_RMW. A sample that closes a group then starts the
// group-end pass: per polarization a memory read, a load step, a bit-serial
// division (skipped when it has no unflagged sample), a squaring step and
// a compare, followed by one result transfer per polarization on out_o.
// No input is taken while the group-end pass runs or results wait; a stalled
// receiver holds the block with the current result steady on out_o.
// Configuration must be written on cfg_we_i/cfg_idx_i/cfg_data_i while idle;
// the block itself does not enforce this. Reset loads the register defaults
// and empties the accumulators; no clearing pass is needed.
`default_nettype none

module flagged_channel_averager_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fca_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fca_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  fca_in_if.sink                             in_i,
  fca_out_if.source                          out_o
);

  localparam int unsigned PW = fca_pkg::POL_W;
  localparam int unsigned NW = fca_pkg::NP_W;
  localparam int unsigned GW = fca_pkg::GRP_W;
  localparam int unsigned CH = fca_pkg::CHAN_W;
  localparam int unsigned SB = fca_pkg::SAMPLE_BITS;
  localparam int unsigned SW = fca_pkg::SUM_W;

  // Configuration registers.
  logic [NW-1:0]                num_pols_q;
  logic [GW-1:0]                group_size_q;
  logic [fca_pkg::SCH_W-1:0]    start_q;
  logic [fca_pkg::NCH_W-1:0]    num_chan_q;
  logic [fca_pkg::AMP_W-1:0]    amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pols_q   <= NW'(4);
      group_size_q <= GW'(1);
      start_q      <= '0;
      num_chan_q   <= fca_pkg::NCH_W'(256);
      amp_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fca_pkg::CFG_NUM_POLS:      num_pols_q   <= cfg_data_i[NW-1:0];
        fca_pkg::CFG_GROUP_SIZE:    group_size_q <= cfg_data_i[GW-1:0];
        fca_pkg::CFG_START_CHANNEL: start_q      <= cfg_data_i[fca_pkg::SCH_W-1:0];
        fca_pkg::CFG_NUM_CHANNELS:  num_chan_q   <= cfg_data_i[fca_pkg::NCH_W-1:0];
        fca_pkg::CFG_AMP_LIMIT:     amp_q        <= cfg_data_i[fca_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective register values after clamping.
  logic [NW-1:0]             np_eff;
  logic [GW-1:0]             grp_eff;
  logic [fca_pkg::NCH_W-1:0] nc_eff;
  logic [CH-1:0]             win_end;

  always_comb begin
    if (num_pols_q == '0) np_eff = NW'(1);
    else if (num_pols_q > NW'(fca_pkg::MAX_POLS)) np_eff = NW'(fca_pkg::MAX_POLS);
    else np_eff = num_pols_q;
    if (group_size_q == '0) grp_eff = GW'(1);
    else if (group_size_q > GW'(fca_pkg::MAX_GROUP)) grp_eff = GW'(fca_pkg::MAX_GROUP);
    else grp_eff = group_size_q;
    if (num_chan_q > fca_pkg::NCH_W'(fca_pkg::MAX_CHANNELS))
      nc_eff = fca_pkg::NCH_W'(fca_pkg::MAX_CHANNELS);
    else nc_eff = num_chan_q;
    win_end = CH'(start_q) + CH'(nc_eff);
  end

  fca_pkg::state_e state_q, state_d;

  // Row position and group state.
  logic [PW-1:0]             pol_cnt_q;
  logic [CH-1:0]             chan_cnt_q;
  logic [GW-1:0]             in_grp_q;
  logic [fca_pkg::OCH_W-1:0] out_chan_q;
  logic                      all_flg_q;
  logic [fca_pkg::MAX_POLS-1:0] ent_valid_q;

  // Captured item.
  logic signed [SB-1:0] re_q, im_q;
  logic                 flg_q, inwin_q, cend_q;
  logic [PW-1:0]        pol_q;

  // Group-end pass.
  logic [PW-1:0]        gp_q, ep_q;
  logic                 gflag_q;
  logic signed [SB-1:0] cur_re_q, cur_im_q;
  logic [31:0]          sq_re_q, sq_im_q, lim2_q;
  logic signed [SB-1:0] avg_re_a [fca_pkg::MAX_POLS];
  logic signed [SB-1:0] avg_im_a [fca_pkg::MAX_POLS];

  // Accumulator memory.
  fca_pkg::acc_t acc_mem [fca_pkg::MAX_POLS];
  fca_pkg::acc_t rd_q, rd_ent, wr_ent;
  logic [PW-1:0] rd_addr;
  logic [PW-1:0] rd_sel;
  logic          wr_en;

  // Item decode at the input transfer.
  logic          in_xfer, out_xfer;
  logic [PW-1:0] pol_cur;
  logic [CH-1:0] chan_cur;
  logic          cend_cur, inwin_cur;
  logic [GW:0]   grp_next;
  logic          grp_done, last_pol, gp_last;
  logic signed [31:0] pr_re, pr_im;
  logic [32:0]   mag2;

  logic                 div_start, div_done;
  logic signed [SB-1:0] div_re, div_im;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign out_xfer  = out_o.valid && out_o.ready;
  assign pol_cur   = in_i.first_of_row ? '0 : pol_cnt_q;
  assign chan_cur  = in_i.first_of_row ? '0 : chan_cnt_q;
  assign cend_cur  = ({1'b0, pol_cur} + NW'(1)) >= np_eff;
  assign inwin_cur = (chan_cur >= CH'(start_q)) && (chan_cur < win_end);
  assign grp_next  = {1'b0, in_grp_q} + (GW + 1)'(1);
  assign grp_done  = grp_next >= {1'b0, grp_eff};
  assign last_pol  = ({1'b0, ep_q} + NW'(1)) == np_eff;
  assign gp_last   = ({1'b0, gp_q} + NW'(1)) >= np_eff;

  // An entry not written since the last clear reads as empty.
  assign rd_sel = (state_q == fca_pkg::ST_RMW) ? pol_q : gp_q;
  assign rd_ent = ent_valid_q[rd_sel] ? rd_q : '0;

  assign wr_en       = (state_q == fca_pkg::ST_RMW) && inwin_q && !flg_q;
  assign wr_ent.re   = rd_ent.re + {{(SW - SB){re_q[SB-1]}}, re_q};
  assign wr_ent.im   = rd_ent.im + {{(SW - SB){im_q[SB-1]}}, im_q};
  assign wr_ent.cnt  = rd_ent.cnt + fca_pkg::CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) acc_mem[pol_q] <= wr_ent;
    rd_q <= acc_mem[rd_addr];
  end

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    div_start   = 1'b0;
    rd_addr     = gp_q;
    unique case (state_q)
      fca_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        rd_addr    = pol_cur;
        if (in_i.valid) state_d = fca_pkg::ST_RMW;
      end
      fca_pkg::ST_RMW: begin
        if (inwin_q && cend_q && grp_done) state_d = fca_pkg::ST_GRD;
        else state_d = fca_pkg::ST_IDLE;
      end
      fca_pkg::ST_GRD: state_d = fca_pkg::ST_GLD;
      fca_pkg::ST_GLD: begin
        if (rd_ent.cnt == '0) begin
          state_d = fca_pkg::ST_GSQ;
        end else begin
          div_start = 1'b1;
          state_d   = fca_pkg::ST_GDIV;
        end
      end
      fca_pkg::ST_GDIV: if (div_done) state_d = fca_pkg::ST_GSQ;
      fca_pkg::ST_GSQ:  state_d = fca_pkg::ST_GCMP;
      fca_pkg::ST_GCMP: state_d = gp_last ? fca_pkg::ST_EMIT : fca_pkg::ST_GRD;
      fca_pkg::ST_EMIT: begin
        out_o.valid = 1'b1;
        if (out_o.ready && last_pol) state_d = fca_pkg::ST_IDLE;
      end
      default: state_d = fca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= fca_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // Control state: row counters, group counters, entry valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_cnt_q   <= '0;
      chan_cnt_q  <= '0;
      in_grp_q    <= '0;
      out_chan_q  <= '0;
      all_flg_q   <= 1'b1;
      ent_valid_q <= '0;
      gp_q        <= '0;
      ep_q        <= '0;
      gflag_q     <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (in_i.first_of_row) begin
          in_grp_q    <= '0;
          out_chan_q  <= '0;
          all_flg_q   <= 1'b1;
          ent_valid_q <= '0;
        end
        if (cend_cur) begin
          pol_cnt_q <= '0;
          if (chan_cur != '1) chan_cnt_q <= chan_cur + CH'(1);
          else chan_cnt_q <= chan_cur;
        end else begin
          pol_cnt_q  <= pol_cur + PW'(1);
          chan_cnt_q <= chan_cur;
        end
      end
      if (state_q == fca_pkg::ST_RMW) begin
        if (wr_en) begin
          ent_valid_q[pol_q] <= 1'b1;
          all_flg_q          <= 1'b0;
        end
        if (inwin_q && cend_q) begin
          if (grp_done) begin
            in_grp_q <= '0;
            gp_q     <= '0;
            gflag_q  <= all_flg_q && flg_q;
          end else begin
            in_grp_q <= grp_next[GW-1:0];
          end
        end
      end
      if (state_q == fca_pkg::ST_GCMP) begin
        if (mag2 <= {1'b0, lim2_q}) gflag_q <= 1'b1;
        if (gp_last) ep_q <= '0;
        else gp_q <= gp_q + PW'(1);
      end
      if (state_q == fca_pkg::ST_EMIT && out_xfer) begin
        if (last_pol) begin
          ent_valid_q <= '0;
          all_flg_q   <= 1'b1;
          out_chan_q  <= out_chan_q + fca_pkg::OCH_W'(1);
        end else begin
          ep_q <= ep_q + PW'(1);
        end
      end
    end
  end

  // Payload registers.
  assign pr_re = 32'(cur_re_q) * 32'(cur_re_q);
  assign pr_im = 32'(cur_im_q) * 32'(cur_im_q);
  assign mag2  = {1'b0, sq_re_q} + {1'b0, sq_im_q};

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      re_q    <= in_i.data_re;
      im_q    <= in_i.data_im;
      flg_q   <= in_i.flagged;
      pol_q   <= pol_cur;
      inwin_q <= inwin_cur;
      cend_q  <= cend_cur;
    end
    if (state_q == fca_pkg::ST_GLD && rd_ent.cnt == '0) begin
      cur_re_q <= '0;
      cur_im_q <= '0;
    end
    if (state_q == fca_pkg::ST_GDIV && div_done) begin
      cur_re_q <= div_re;
      cur_im_q <= div_im;
    end
    if (state_q == fca_pkg::ST_GSQ) begin
      sq_re_q <= unsigned'(pr_re);
      sq_im_q <= unsigned'(pr_im);
      lim2_q  <= 32'(amp_q) * 32'(amp_q);
    end
    if (state_q == fca_pkg::ST_GCMP) begin
      avg_re_a[gp_q] <= cur_re_q;
      avg_im_a[gp_q] <= cur_im_q;
    end
  end

  fca_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_re_i (rd_ent.re),
    .num_im_i (rd_ent.im),
    .den_i    (rd_ent.cnt),
    .done_o   (div_done),
    .quo_re_o (div_re),
    .quo_im_o (div_im)
  );

  // Result transfer payload.
  assign out_o.avg_re      = avg_re_a[ep_q];
  assign out_o.avg_im      = avg_im_a[ep_q];
  assign out_o.pol_index   = ep_q;
  assign out_o.out_channel = out_chan_q;
  assign out_o.group_flag  = gflag_q;
  assign out_o.last        = last_pol;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  // One input sample as the sender offers it.
  typedef struct {
    logic signed [fca_pkg::SAMPLE_BITS-1:0] re;
    logic signed [fca_pkg::SAMPLE_BITS-1:0] im;
    logic                                   flagged;
    logic                                   first;
  } sample_t;

  // One averaged result as it leaves the block.
  typedef struct {
    logic signed [fca_pkg::SAMPLE_BITS-1:0] re;
    logic signed [fca_pkg::SAMPLE_BITS-1:0] im;
    logic [fca_pkg::POL_W-1:0]              pol;
    logic [fca_pkg::OCH_W-1:0]              och;
    logic                                   flag;
    logic                                   last;
  } avg_t;

  // Tracks the averaging state and holds the averages still to arrive.
  class avg_scoreboard;
    logic [fca_pkg::NP_W-1:0]  np_r;
    logic [fca_pkg::GRP_W-1:0] gs_r;
    logic [fca_pkg::SCH_W-1:0] sc_r;
    logic [fca_pkg::NCH_W-1:0] nc_r;
    logic [fca_pkg::AMP_W-1:0] amp_r;
    int unsigned               pol_cnt;
    int unsigned               chan_cnt;
    int unsigned               grp_cnt;
    logic [fca_pkg::OCH_W-1:0] och_cnt;
    longint                    sum_re[fca_pkg::MAX_POLS];
    longint                    sum_im[fca_pkg::MAX_POLS];
    int unsigned               n_valid[fca_pkg::MAX_POLS];
    bit                        all_fl;
    avg_t                      pending_avgs[$];
    int                        errors;
    int                        seen;

    function void clear_group();
      for (int p = 0; p < fca_pkg::MAX_POLS; p++) begin
        sum_re[p] = 0;
        sum_im[p] = 0;
        n_valid[p] = 0;
      end
      grp_cnt = 0;
      all_fl = 1'b1;
    endfunction

    function void reset_state();
      np_r = fca_pkg::NP_W'(4);
      gs_r = fca_pkg::GRP_W'(1);
      sc_r = '0;
      nc_r = fca_pkg::NCH_W'(256);
      amp_r = '0;
      pol_cnt = 0;
      chan_cnt = 0;
      och_cnt = '0;
      errors = 0;
      seen = 0;
      clear_group();
    endfunction

    function void set_reg(fca_pkg::cfg_idx_e idx, logic [fca_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        fca_pkg::CFG_NUM_POLS:      np_r = d[fca_pkg::NP_W-1:0];
        fca_pkg::CFG_GROUP_SIZE:    gs_r = d[fca_pkg::GRP_W-1:0];
        fca_pkg::CFG_START_CHANNEL: sc_r = d[fca_pkg::SCH_W-1:0];
        fca_pkg::CFG_NUM_CHANNELS:  nc_r = d[fca_pkg::NCH_W-1:0];
        fca_pkg::CFG_AMP_LIMIT:     amp_r = d[fca_pkg::AMP_W-1:0];
        default: ;
      endcase
    endfunction

    // Folds one accepted sample in and queues the averages of a closed group.
    function void note_sample(sample_t s);
      int unsigned np, gs, nc, pol;
      bit          chan_end, flag;
      longint      are[fca_pkg::MAX_POLS], aim[fca_pkg::MAX_POLS];
      longint      lim2, mag2;
      avg_t        r;
      np = (np_r == 0) ? 1 : (np_r > fca_pkg::MAX_POLS ? fca_pkg::MAX_POLS : np_r);
      gs = (gs_r == 0) ? 1 : (gs_r > fca_pkg::MAX_GROUP ? fca_pkg::MAX_GROUP : gs_r);
      nc = (nc_r > fca_pkg::MAX_CHANNELS) ? fca_pkg::MAX_CHANNELS : nc_r;
      if (s.first) begin
        pol_cnt = 0;
        chan_cnt = 0;
        och_cnt = '0;
        clear_group();
      end
      pol = pol_cnt;
      chan_end = (pol + 1 >= np);
      if (chan_cnt >= sc_r && chan_cnt < sc_r + nc && pol < fca_pkg::MAX_POLS) begin
        if (!s.flagged) begin
          sum_re[pol] += s.re;
          sum_im[pol] += s.im;
          n_valid[pol]++;
          all_fl = 1'b0;
        end
        if (chan_end) begin
          grp_cnt++;
          if (grp_cnt >= gs) begin
            lim2 = longint'(amp_r) * longint'(amp_r);
            flag = all_fl;
            for (int p = 0; p < np; p++) begin
              if (n_valid[p] != 0) begin
                are[p] = sum_re[p] / longint'(n_valid[p]);
                aim[p] = sum_im[p] / longint'(n_valid[p]);
              end else begin
                are[p] = 0;
                aim[p] = 0;
              end
              mag2 = are[p] * are[p] + aim[p] * aim[p];
              if (mag2 <= lim2) flag = 1'b1;
            end
            for (int p = 0; p < np; p++) begin
              r.re = are[p][fca_pkg::SAMPLE_BITS-1:0];
              r.im = aim[p][fca_pkg::SAMPLE_BITS-1:0];
              r.pol = p[fca_pkg::POL_W-1:0];
              r.och = och_cnt;
              r.flag = flag;
              r.last = (p + 1 == np);
              pending_avgs.push_back(r);
            end
            och_cnt = och_cnt + fca_pkg::OCH_W'(1);
            clear_group();
          end
        end
      end
      if (chan_end) begin
        pol_cnt = 0;
        if (chan_cnt != 32'hFFFF_FFFF) chan_cnt++;
      end else begin
        pol_cnt = pol + 1;
      end
    endfunction

    // Compares one result transfer with the oldest pending average.
    function void check_avg(avg_t a);
      avg_t e;
      seen++;
      if (pending_avgs.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d pol=%0d och=%0d", $time,
                 a.re, a.im, a.pol, a.och);
        errors++;
        return;
      end
      e = pending_avgs.pop_front();
      if (a.re !== e.re) begin
        $display("%0t: avg_re expected %0d actual %0d", $time, e.re, a.re);
        errors++;
      end
      if (a.im !== e.im) begin
        $display("%0t: avg_im expected %0d actual %0d", $time, e.im, a.im);
        errors++;
      end
      if (a.pol !== e.pol) begin
        $display("%0t: pol_index expected %0d actual %0d", $time, e.pol, a.pol);
        errors++;
      end
      if (a.och !== e.och) begin
        $display("%0t: out_channel expected %0d actual %0d", $time, e.och, a.och);
        errors++;
      end
      if (a.flag !== e.flag) begin
        $display("%0t: group_flag expected %0b actual %0b", $time, e.flag, a.flag);
        errors++;
      end
      if (a.last !== e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, a.last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [fca_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [fca_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                             calm;
  bit                             hold_go;
  bit                             hold_started = 1'b0;
  int                             hold_cnt = 0;
  int                             n_items;
  avg_scoreboard                  sb;

  fca_in_if  in_ch ();
  fca_out_if out_ch ();

  flagged_channel_averager_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Watch both channels for transfers.
  always @(posedge clk_i) begin
    avg_t a;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      sb.note_sample('{in_ch.data_re, in_ch.data_im, in_ch.flagged, in_ch.first_of_row});
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      a.re = out_ch.avg_re;
      a.im = out_ch.avg_im;
      a.pol = out_ch.pol_index;
      a.och = out_ch.out_channel;
      a.flag = out_ch.group_flag;
      a.last = out_ch.last;
      sb.check_avg(a);
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_go && !hold_started) begin
      hold_started = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 34);
    end
  end

  // Offers one sample and waits for its transfer.
  task automatic send(logic signed [15:0] re, logic signed [15:0] im, bit fl, bit first);
    if (!calm && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_re <= re;
    in_ch.data_im <= im;
    in_ch.flagged <= fl;
    in_ch.first_of_row <= first;
    n_items++;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Lets every pending average arrive, then lets the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_avgs.size() != 0);
    repeat (200) @(posedge clk_i);
  endtask

  // Writes all five registers while the block is idle.
  task automatic configure(int np, int gs, int sc, int nc, int amp);
    fca_pkg::cfg_idx_e idx[5];
    int                val[5];
    idx = '{fca_pkg::CFG_NUM_POLS, fca_pkg::CFG_GROUP_SIZE, fca_pkg::CFG_START_CHANNEL,
            fca_pkg::CFG_NUM_CHANNELS, fca_pkg::CFG_AMP_LIMIT};
    val = '{np, gs, sc, nc, amp};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= fca_pkg::CFG_DATA_W'(val[i]);
      sb.set_reg(idx[i], fca_pkg::CFG_DATA_W'(val[i]));
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(7) - 3);
      default: return 16'($urandom());
    endcase
  endfunction

  // Sends a row of random samples; most rows start with a row marker.
  task automatic send_row(int samples, bit first, int fl_pct);
    bit fl;
    for (int i = 0; i < samples; i++) begin
      fl = ($urandom_range(99) < fl_pct);
      send(rand_value(), rand_value(), fl, (i == 0) ? first : ($urandom_range(199) == 0));
    end
  endtask

  initial begin
    int np, gs, sc, nc, amp;
    sb = new();
    sb.reset_state();
    rst_ni = 0;
    cfg_we = 0;
    cfg_idx = fca_pkg::CFG_NUM_POLS;
    cfg_data = '0;
    calm = 0;
    hold_go = 0;
    n_items = 0;
    in_ch.valid = 0;
    in_ch.data_re = 0;
    in_ch.data_im = 0;
    in_ch.flagged = 0;
    in_ch.first_of_row = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples at reset settings: extremes, a zero count, all flagged.
    send(16'sh7FFF, 16'sh8000, 1'b0, 1'b1);
    send(16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
    send(16'sh1234, 16'sh4321, 1'b1, 1'b0);
    send(16'sh0000, 16'sh0000, 1'b0, 1'b0);
    for (int p = 0; p < 4; p++) send(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
    // A row marker in the middle of a channel drops that partial channel.
    send(16'sh0100, 16'sh0200, 1'b0, 1'b0);
    send(16'sh0300, 16'sh0400, 1'b0, 1'b0);
    for (int p = 0; p < 4; p++) send(16'(16 + p), -16'sh0020, 1'b0, p == 0);
    drain();

    // Averaging with a high limit, then truncation toward zero of negatives.
    configure(4, 2, 1, 3, 65535);
    for (int i = 0; i < 16; i++) send(16'(i - 7), 16'(3 - i), i == 5, i == 0);
    drain();

    // Register extremes beyond the ranges and a window at the end of the row.
    configure(0, 0, 30, 1, 0);
    send_row(32, 1'b1, 10);
    drain();
    configure(7, 511, 0, 8191, 46341);
    send_row(40, 1'b1, 20);
    drain();
    configure(1, 100, 2, 300, 100);
    send_row(110, 1'b1, 15);
    drain();
    configure(2, 3, 0, 0, 0);
    send_row(12, 1'b1, 0);
    drain();

    // Change the polarization count mid-row without a new row marker.
    configure(4, 2, 0, 20, 10);
    send_row(6, 1'b1, 10);
    drain();
    configure(2, 1, 0, 20, 10);
    send_row(8, 1'b0, 10);
    drain();

    // Random phases: mostly well-formed rows, some noise and cut rows.
    for (int ph = 0; n_items < 400 || ph < 6; ph++) begin
      np = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
      gs = ($urandom_range(9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 4);
      sc = $urandom_range(3);
      nc = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 10);
      case ($urandom_range(3))
        0: amp = 0;
        1: amp = $urandom_range(300);
        2: amp = $urandom_range(46341);
        default: amp = $urandom();
      endcase
      // The hold-off phase closes a group on every used channel.
      if (ph == 5) begin
        gs = 1;
        nc = 10;
      end
      configure(np, gs, sc, nc, amp);
      calm = (ph == 3);
      if (ph == 5) begin
        calm = 1;
        hold_go = 1;
      end
      if (ph != 5 && $urandom_range(9) == 0)
        send_row($urandom_range(1, 12), 1'($urandom_range(1)), 50);
      else
        send_row((sc + 12) * ((np == 0) ? 1 : (np > 4 ? 4 : np)), 1'b1,
                 ($urandom_range(4) == 0) ? 90 : 25);
      calm = 0;
      drain();
    end

    if (sb.errors == 0)
      $display("flagged_channel_averager_top verification clean");
    else
      $display("flagged_channel_averager_top verification failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("flagged_channel_averager_top verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/fca_pkg.sv
rtl/core/fca_in_if.sv
rtl/core/fca_out_if.sv
rtl/core/fca_div.sv
rtl/core/flagged_channel_averager_top.sv
tb/sv/tb.sv
